>>> sv/nrfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nrfe_pkg;

    localparam int MAX_WORD    = 32;
    localparam int PATH_LEVELS = 4;
    localparam int NUM_TARGETS = 4;
    localparam int WORD_IDX_W  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int WORD_LEN_W  = $clog2(MAX_WORD + 1);
    localparam int COUNT_W     = 16;
    localparam int DEPTH_W     = 5;
    localparam int PATH_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 5'd31;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [CFG_IDX_W-1:0] CFG_PATH_DEPTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_3   = 3'd4;

    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] addr;
        logic [7:0]            data;
    } buf_wr_t;

    typedef struct packed {
        logic                  found;
        logic                  empty;
        logic                  truncated;
        logic [WORD_IDX_W-1:0] last_idx;
    } job_t;

endpackage
`default_nettype wire

>>> sv/nrfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
module nrfe_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [nrfe_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire logic [nrfe_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,
    input  wire logic                               s_tlast,
    input  wire logic                               busy,
    input  wire logic                               q_full,
    output logic                                    job_push,
    output nrfe_pkg::job_t                          job,
    output nrfe_pkg::buf_wr_t                       buf_wr
);
    import nrfe_pkg::*;

    typedef enum logic [1:0] {PH_SEEK, PH_SCAN, PH_DONE} phase_t;

    phase_t                phase_reg, phase_next;
    logic                  pending_reg, pending_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [COUNT_W-1:0]    count_reg [PATH_LEVELS];
    logic [COUNT_W-1:0]    count_next [PATH_LEVELS];
    logic                  after_reg, after_next;
    logic [WORD_LEN_W-1:0] len_reg, len_next;
    logic                  ovf_reg, ovf_next;
    logic [PATH_W-1:0]     path_depth_reg;
    logic [COUNT_W-1:0]    target_reg [NUM_TARGETS];

    logic                  is_open, is_close, is_comma, is_word;
    logic                  enter_scan, scanning, writes_buf, accept, push_c, reached;
    logic [PATH_W-1:0]     lim;
    logic [WORD_LEN_W-1:0] len_work;
    job_t                  job_c;

    function automatic job_t make_job(logic fnd, logic [WORD_LEN_W-1:0] len, logic ovf);
        job_t j;
        j.found     = fnd;
        j.empty     = (len == '0);
        j.truncated = ovf;
        j.last_idx  = WORD_IDX_W'(len - WORD_LEN_W'(1));
        return j;
    endfunction

    always_comb begin
        is_open  = (s_tdata == CH_LPAREN) || (s_tdata == CH_LBRACK) || (s_tdata == CH_LBRACE);
        is_close = (s_tdata == CH_RPAREN) || (s_tdata == CH_RBRACK) || (s_tdata == CH_RBRACE);
        is_comma = (s_tdata == CH_COMMA);
        is_word  = !is_open && !is_close && !is_comma;

        enter_scan = (phase_reg == PH_SEEK) && pending_reg && (s_tdata != CH_LBRACE);
        scanning   = (phase_reg == PH_SCAN) || enter_scan;
        writes_buf = !s_tlast && scanning && is_word &&
                     (after_reg || (len_reg < WORD_LEN_W'(MAX_WORD)));
        s_tready   = !q_full && !(busy && writes_buf);
        accept     = s_tvalid && s_tready;

        lim = (path_depth_reg > PATH_W'(PATH_LEVELS)) ? PATH_W'(PATH_LEVELS) : path_depth_reg;

        phase_next   = phase_reg;
        pending_next = pending_reg;
        depth_next   = depth_reg;
        for (int i = 0; i < PATH_LEVELS; i++) begin
            count_next[i] = count_reg[i];
        end
        after_next  = after_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        len_work    = len_reg;
        push_c      = 1'b0;
        job_c       = make_job(1'b0, len_reg, ovf_reg);
        buf_wr.addr = WORD_IDX_W'(len_reg);
        buf_wr.data = s_tdata;
        reached     = 1'b1;

        if (s_tlast) begin
            push_c       = (phase_reg != PH_DONE);
            phase_next   = PH_SEEK;
            pending_next = 1'b0;
            depth_next   = '0;
            for (int i = 0; i < PATH_LEVELS; i++) begin
                count_next[i] = '0;
            end
            after_next = 1'b1;
            len_next   = '0;
            ovf_next   = 1'b0;
        end else if (phase_reg == PH_DONE) begin
            phase_next = PH_DONE;
        end else if (!scanning) begin
            if (s_tdata == CH_LBRACE) begin
                pending_next = 1'b1;
            end
        end else begin
            phase_next   = PH_SCAN;
            pending_next = 1'b0;
            if (is_open) begin
                if (depth_reg < DEPTH_MAX) begin
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                after_next = 1'b1;
            end else if (is_close) begin
                for (int i = 0; i < PATH_LEVELS; i++) begin
                    if (depth_reg == DEPTH_W'(i)) begin
                        count_next[i] = '0;
                    end
                end
                if (depth_reg != '0) begin
                    depth_next = depth_reg - DEPTH_W'(1);
                end
                after_next = 1'b1;
            end else if (is_comma) begin
                for (int i = 0; i < PATH_LEVELS; i++) begin
                    if (depth_reg == DEPTH_W'(i) && count_reg[i] != COUNT_MAX) begin
                        count_next[i] = count_reg[i] + COUNT_W'(1);
                    end
                end
                after_next = 1'b1;
            end else begin
                if (after_reg) begin
                    len_work   = '0;
                    ovf_next   = 1'b0;
                    after_next = 1'b0;
                end
                buf_wr.addr = WORD_IDX_W'(len_work);
                if (len_work < WORD_LEN_W'(MAX_WORD)) begin
                    len_next = len_work + WORD_LEN_W'(1);
                end else begin
                    len_next = len_work;
                    ovf_next = 1'b1;
                end
            end

            for (int i = 0; i < PATH_LEVELS; i++) begin
                if (PATH_W'(i) < lim && count_next[i] < target_reg[i]) begin
                    reached = 1'b0;
                end
            end
            if (reached) begin
                push_c     = 1'b1;
                job_c      = make_job(1'b1, len_next, ovf_next);
                phase_next = PH_DONE;
            end
        end

        buf_wr.en = accept && writes_buf;
        job_push  = accept && push_c;
        job       = job_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SEEK;
            pending_reg <= 1'b0;
            depth_reg   <= '0;
            for (int i = 0; i < PATH_LEVELS; i++) begin
                count_reg[i] <= '0;
            end
            after_reg <= 1'b1;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            depth_reg   <= depth_next;
            for (int i = 0; i < PATH_LEVELS; i++) begin
                count_reg[i] <= count_next[i];
            end
            after_reg <= after_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_depth_reg <= '0;
            for (int i = 0; i < NUM_TARGETS; i++) begin
                target_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_PATH_DEPTH: path_depth_reg <= cfg_wr_data[PATH_W-1:0];
                CFG_TARGET_0:   target_reg[0] <= cfg_wr_data;
                CFG_TARGET_1:   target_reg[1] <= cfg_wr_data;
                CFG_TARGET_2:   target_reg[2] <= cfg_wr_data;
                CFG_TARGET_3:   target_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/nrfe_job_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module nrfe_job_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  nrfe_pkg::job_t      push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output nrfe_pkg::job_t      head_job
);
    import nrfe_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    always_comb begin
        full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
        valid    = (count_reg != '0);
        head_job = entry_reg[rd_ptr_reg];
        do_push  = push && !full;
        do_pop   = pop && valid;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/nrfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
module nrfe_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  nrfe_pkg::buf_wr_t   buf_wr,
    input  wire logic           q_valid,
    input  nrfe_pkg::job_t      q_job,
    output logic                q_pop,
    output logic                active,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [2:0]          m_tuser
);
    import nrfe_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_SHOW} state_t;

    state_t                state_reg;
    job_t                  job_reg;
    logic [WORD_IDX_W-1:0] idx_reg;
    logic [7:0]            mem [MAX_WORD];
    logic [7:0]            rd_data;
    logic                  at_last;

    always_ff @(posedge aclk) begin
        if (buf_wr.en) begin
            mem[buf_wr.addr] <= buf_wr.data;
        end
        rd_data <= mem[idx_reg];
    end

    always_comb begin
        q_pop    = (state_reg == S_IDLE) && q_valid;
        active   = (state_reg != S_IDLE);
        at_last  = job_reg.empty || (idx_reg == job_reg.last_idx);
        m_tvalid = (state_reg == S_SHOW);
        m_tdata  = job_reg.empty ? 8'h00 : rd_data;
        m_tlast  = at_last;
        m_tuser  = {job_reg.truncated, job_reg.empty, job_reg.found};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        job_reg   <= q_job;
                        idx_reg   <= '0;
                        state_reg <= q_job.empty ? S_SHOW : S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_SHOW;
                end
                S_SHOW: begin
                    if (m_tready) begin
                        if (at_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + WORD_IDX_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/nested_record_field_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Beat contents
// s_       in         tdata[7:0] char_byte, tlast record_end
// m_       out        tdata[7:0] word_byte, tlast last_byte,
//                     tuser[0] found, tuser[1] empty_word, tuser[2] truncated
// cfg_     in         one register write per cycle, index 0 path depth, 1..4 targets
//
// The parser takes one character per cycle while the job queue has room. Each emitted
// character takes a word-buffer read, then an output beat, once the word is picked up.
// While a word is queued or being sent, a character that would enter the word
// buffer is held off; other characters keep flowing. Reset is synchronous,
// active low, and clears the parser and the configuration; no clearing pass.
module nested_record_field_extractor (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [nrfe_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire logic [nrfe_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // char_byte
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,   // word_byte
    output logic                                    m_tlast,
    output logic [2:0]                              m_tuser    // found, empty_word, truncated
);
    import nrfe_pkg::*;

    job_t    job, q_job;
    buf_wr_t buf_wr;
    logic    job_push, q_full, q_valid, q_pop, back_active, busy;

    assign busy = q_valid || back_active;

    nrfe_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .busy         (busy),
        .q_full       (q_full),
        .job_push     (job_push),
        .job          (job),
        .buf_wr       (buf_wr)
    );

    nrfe_job_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_job (q_job)
    );

    nrfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .buf_wr   (buf_wr),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .active   (back_active),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_buf_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_wr.en |-> !busy)
        else $error("Word buffer written while a word is pending.");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> !q_full)
        else $error("Word job pushed into a full queue.");

    a_empty_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && m_tdata == 8'h00))
        else $error("Empty word beat is not a single zero beat.");

endmodule
`default_nettype wire
